/* hdl/oad_pkg.sv */
// ----------------------------------------------------------------------------
// oad_pkg
// Shared state codes, register indexes and types of the bump-and-turn
// navigation chart.
// ----------------------------------------------------------------------------
package oad_pkg;

  localparam int unsigned StateW = 4;
  localparam int unsigned SpeedW = 10;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [StateW-1:0] ST_INITIAL       = 4'd0;
  localparam logic [StateW-1:0] ST_PAUSE_REL     = 4'd1;
  localparam logic [StateW-1:0] ST_UNPAUSE_PRESS = 4'd2;
  localparam logic [StateW-1:0] ST_UNPAUSE_REL   = 4'd3;
  localparam logic [StateW-1:0] ST_DRIVE         = 4'd4;
  localparam logic [StateW-1:0] ST_TURN_R        = 4'd5;
  localparam logic [StateW-1:0] ST_TURN_L        = 4'd6;
  localparam logic [StateW-1:0] ST_REPAIR_R      = 4'd7;
  localparam logic [StateW-1:0] ST_REPAIR_L      = 4'd8;

  localparam logic [CfgAddrW-1:0] REG_DRIVE_SPEED     = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_TURN_SPEED      = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_REPAIR_DISTANCE = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_TURN_ANGLE      = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_REPAIR_BAND     = 3'd4;

  localparam logic [8:0] SPEED_MAX = 9'd500;

  typedef struct packed {
    logic [8:0]  drive_speed;
    logic [8:0]  turn_speed;
    logic [15:0] repair_distance;
    logic [8:0]  turn_angle;
    logic [7:0]  repair_band;
  } oad_cfg_t;

  typedef struct packed {
    logic [StateW-1:0] chart;
    logic [StateW-1:0] resume;
    logic [31:0]       man_dist;
    logic [31:0]       man_ang;
    logic              obstacle;
  } oad_state_t;

  typedef struct packed {
    logic [31:0] net_distance;
    logic [31:0] net_angle;
    logic        play_button;
    logic        wall_seen;
    logic        bump_left;
    logic        bump_right;
  } oad_beat_t;

endpackage

/* hdl/obstacle_avoid_drive_fsm.sv */
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_fsm
// Bump-and-turn navigation chart with pause handling and heading repair.
// ----------------------------------------------------------------------------
// Each accepted sensor beat produces one result beat carrying the wheel speed
// commands and state code after that beat's transition. A beat is registered
// at the input, passes the chart logic and lands in the output register when
// the output side is free. One beat is taken per cycle while the output side
// keeps up; the chart state loop through a single register sets that rate.
// The user must write configuration through cfg_we_i/cfg_addr_i/cfg_wdata_i
// only while no beat is in flight; the block itself does not enforce this.
module obstacle_avoid_drive_fsm
  import oad_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         net_distance_i,
  input  logic [31:0]         net_angle_i,
  input  logic                play_button_i,
  input  logic                wall_seen_i,
  input  logic                bump_left_i,
  input  logic                bump_right_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SpeedW-1:0]   left_speed_o,
  output logic [SpeedW-1:0]   right_speed_o,
  output logic [StateW-1:0]   mode_o
);

  oad_cfg_t          cfg_q;
  oad_state_t        state_q, state_d;
  oad_beat_t         beat_q;
  logic              beat_valid_q;
  logic              out_valid_q;
  logic [SpeedW-1:0] left_q, left_d;
  logic [SpeedW-1:0] right_q, right_d;
  logic [StateW-1:0] mode_q;
  logic              out_free;
  logic              advance;
  logic              take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = beat_valid_q && out_free;
  assign in_stall_o = beat_valid_q && !out_free;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_speed     <= 9'd200;
      cfg_q.turn_speed      <= 9'd100;
      cfg_q.repair_distance <= 16'd300;
      cfg_q.turn_angle      <= 9'd15;
      cfg_q.repair_band     <= 8'd6;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DRIVE_SPEED:     cfg_q.drive_speed     <= cfg_wdata_i[8:0];
        REG_TURN_SPEED:      cfg_q.turn_speed      <= cfg_wdata_i[8:0];
        REG_REPAIR_DISTANCE: cfg_q.repair_distance <= cfg_wdata_i;
        REG_TURN_ANGLE:      cfg_q.turn_angle      <= cfg_wdata_i[8:0];
        REG_REPAIR_BAND:     cfg_q.repair_band     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      beat_q.net_distance <= net_distance_i;
      beat_q.net_angle    <= net_angle_i;
      beat_q.play_button  <= play_button_i;
      beat_q.wall_seen    <= wall_seen_i;
      beat_q.bump_left    <= bump_left_i;
      beat_q.bump_right   <= bump_right_i;
    end
    if (advance) begin
      left_q  <= left_d;
      right_q <= right_d;
      mode_q  <= state_d.chart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (take) begin
        beat_valid_q <= 1'b1;
      end else if (advance) begin
        beat_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.chart    <= ST_INITIAL;
      state_q.resume   <= ST_DRIVE;
      state_q.man_dist <= '0;
      state_q.man_ang  <= '0;
      state_q.obstacle <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  oad_chart u_chart (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .beat_i        (beat_q),
    .state_o       (state_d),
    .left_speed_o  (left_d),
    .right_speed_o (right_d)
  );

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign mode_o        = mode_q;

`ifndef NO_ASSERTIONS
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.chart <= ST_REPAIR_L && state_q.resume <= ST_REPAIR_L)
    else $error("chart state out of range");

  a_pause_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o <= ST_UNPAUSE_REL |-> left_speed_o == '0 && right_speed_o == '0)
    else $error("wheels move in a pause state");

  a_drive_straight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == ST_DRIVE |-> left_speed_o == right_speed_o)
    else $error("unequal wheel speeds while driving");

  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && mode_q == state_q.chart)
    else $error("result does not match chart state");
`endif

endmodule

/* hdl/oad_chart.sv */
// ----------------------------------------------------------------------------
// oad_chart
// Next-state and wheel speed logic of the navigation chart for one beat.
// ----------------------------------------------------------------------------
module oad_chart
  import oad_pkg::*;
(
  input  oad_cfg_t          cfg_i,
  input  oad_state_t        state_i,
  input  oad_beat_t         beat_i,
  output oad_state_t        state_o,
  output logic [SpeedW-1:0] left_speed_o,
  output logic [SpeedW-1:0] right_speed_o
);

  logic signed [32:0] dist_diff;
  logic signed [32:0] ang_diff;
  logic [32:0]        dist_mag;
  logic [32:0]        turn_mag;
  logic [32:0]        ang_mag;
  logic signed [31:0] ang_s;
  logic signed [31:0] band_s;
  logic               dist_hit;
  logic               turn_hit;
  logic               in_band;
  logic [8:0]         drive_sat;
  logic [8:0]         turn_sat;
  logic [SpeedW-1:0]  drive_pos;
  logic [SpeedW-1:0]  turn_pos;
  logic [SpeedW-1:0]  turn_neg;
  oad_state_t         marked;

  assign ang_s     = $signed(beat_i.net_angle);
  assign band_s    = $signed({24'd0, cfg_i.repair_band});
  assign dist_diff = $signed({beat_i.net_distance[31], beat_i.net_distance})
                   - $signed({state_i.man_dist[31], state_i.man_dist});
  assign ang_diff  = $signed({beat_i.net_angle[31], beat_i.net_angle})
                   - $signed({state_i.man_ang[31], state_i.man_ang});
  assign dist_mag  = dist_diff[32] ? 33'(-dist_diff) : 33'(dist_diff);
  assign turn_mag  = ang_diff[32] ? 33'(-ang_diff) : 33'(ang_diff);
  assign ang_mag   = beat_i.net_angle[31]
                   ? 33'(-$signed({1'b1, beat_i.net_angle}))
                   : {1'b0, beat_i.net_angle};
  assign dist_hit  = dist_mag >= {17'd0, cfg_i.repair_distance};
  assign turn_hit  = turn_mag >= {24'd0, cfg_i.turn_angle};
  assign in_band   = ang_mag < {25'd0, cfg_i.repair_band};

  always_comb begin
    marked          = state_i;
    marked.man_dist = beat_i.net_distance;
    marked.man_ang  = beat_i.net_angle;
  end

  always_comb begin
    state_o = state_i;
    if (state_i.chart <= ST_UNPAUSE_REL || beat_i.play_button) begin
      case (state_i.chart)
        ST_INITIAL: begin
          state_o.chart = ST_UNPAUSE_PRESS;
        end
        ST_PAUSE_REL: begin
          if (!beat_i.play_button) state_o.chart = ST_UNPAUSE_PRESS;
        end
        ST_UNPAUSE_REL: begin
          if (!beat_i.play_button) state_o.chart = state_i.resume;
        end
        ST_UNPAUSE_PRESS: begin
          if (beat_i.play_button) state_o.chart = ST_UNPAUSE_REL;
        end
        default: begin
          state_o.resume = state_i.chart;
          state_o.chart  = ST_PAUSE_REL;
        end
      endcase
    end else begin
      case (state_i.chart)
        ST_DRIVE: begin
          if (beat_i.wall_seen || beat_i.bump_left || beat_i.bump_right) begin
            state_o          = marked;
            state_o.obstacle = 1'b1;
            if (beat_i.wall_seen) begin
              state_o.chart = (ang_s >= 0) ? ST_TURN_R : ST_TURN_L;
            end else if (beat_i.bump_left) begin
              state_o.chart = ST_TURN_R;
            end else begin
              state_o.chart = ST_TURN_L;
            end
          end else if (dist_hit) begin
            if (state_i.obstacle) begin
              state_o          = marked;
              state_o.obstacle = 1'b0;
            end else if (ang_s >= band_s) begin
              state_o       = marked;
              state_o.chart = ST_REPAIR_R;
            end else if (ang_s <= -band_s) begin
              state_o       = marked;
              state_o.chart = ST_REPAIR_L;
            end
          end
        end
        ST_TURN_R, ST_TURN_L: begin
          if (!beat_i.wall_seen && turn_hit) begin
            state_o       = marked;
            state_o.chart = ST_DRIVE;
          end
        end
        ST_REPAIR_R, ST_REPAIR_L: begin
          if (in_band) begin
            state_o       = marked;
            state_o.chart = ST_DRIVE;
          end
        end
        default: begin
          state_o = state_i;
        end
      endcase
    end
  end

  assign drive_sat = (cfg_i.drive_speed > SPEED_MAX) ? SPEED_MAX : cfg_i.drive_speed;
  assign turn_sat  = (cfg_i.turn_speed > SPEED_MAX) ? SPEED_MAX : cfg_i.turn_speed;
  assign drive_pos = {1'b0, drive_sat};
  assign turn_pos  = {1'b0, turn_sat};
  assign turn_neg  = -turn_pos;

  always_comb begin
    case (state_o.chart)
      ST_DRIVE: begin
        left_speed_o  = drive_pos;
        right_speed_o = drive_pos;
      end
      ST_TURN_R, ST_REPAIR_R: begin
        left_speed_o  = turn_pos;
        right_speed_o = turn_neg;
      end
      ST_TURN_L, ST_REPAIR_L: begin
        left_speed_o  = turn_neg;
        right_speed_o = turn_pos;
      end
      default: begin
        left_speed_o  = '0;
        right_speed_o = '0;
      end
    endcase
  end

endmodule
